// ===== src/feg_pkg.sv =====
// Shared types and constants for the fade envelope generator.
`timescale 1ns / 1ps
`default_nettype none

package feg_pkg;

  localparam int unsigned TICK_W   = 16;
  localparam int unsigned ALPHA_W  = 8;
  localparam int unsigned ACC_W    = 18;
  localparam int unsigned PROD_W   = TICK_W + ALPHA_W;
  localparam int unsigned DIV_STEPS = ALPHA_W;
  localparam int unsigned DCNT_W   = $clog2(DIV_STEPS);

  localparam logic [TICK_W-1:0]  FADE_IN_RST  = TICK_W'(1);
  localparam logic [TICK_W-1:0]  HOLD_RST     = '0;
  localparam logic [TICK_W-1:0]  FADE_OUT_RST = '0;
  localparam logic [ALPHA_W-1:0] MAX_OPA_RST  = '1;

  // configuration register indexes
  localparam logic [1:0] REG_FADE_IN  = 2'd0;
  localparam logic [1:0] REG_HOLD     = 2'd1;
  localparam logic [1:0] REG_FADE_OUT = 2'd2;
  localparam logic [1:0] REG_MAX_OPA  = 2'd3;

  typedef struct packed {
    logic [TICK_W-1:0]  fade_in_ticks;
    logic [TICK_W-1:0]  hold_ticks;
    logic [TICK_W-1:0]  fade_out_ticks;
    logic [ALPHA_W-1:0] max_opacity;
  } cfg_t;

  typedef struct packed {
    logic load;      // latch the input beat
    logic calc;      // accumulate, leftover
    logic phase;     // pick envelope phase
    logic mul;       // form dividend, seed divider
    logic div_step;  // one restoring divide step
    logic finish;    // load output register
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic out_free;
  } sts_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CALC  = 6'b000010,
    ST_PHASE = 6'b000100,
    ST_MUL   = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_FIN   = 6'b100000
  } state_t;

endpackage

`default_nettype wire

// ===== src/feg_regs.sv =====
// APB configuration registers of the fade envelope generator.
`timescale 1ns / 1ps
`default_nettype none

module feg_regs import feg_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready,
  output cfg_t             cfg
);

  cfg_t cfg_r;
  logic wr_en;
  logic [1:0] idx;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel & cfg_penable & cfg_pwrite;
  assign idx = cfg_paddr[3:2];
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fade_in_ticks  <= FADE_IN_RST;
      cfg_r.hold_ticks     <= HOLD_RST;
      cfg_r.fade_out_ticks <= FADE_OUT_RST;
      cfg_r.max_opacity    <= MAX_OPA_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_FADE_IN:  cfg_r.fade_in_ticks  <= cfg_pwdata[TICK_W-1:0];
        REG_HOLD:     cfg_r.hold_ticks     <= cfg_pwdata[TICK_W-1:0];
        REG_FADE_OUT: cfg_r.fade_out_ticks <= cfg_pwdata[TICK_W-1:0];
        REG_MAX_OPA:  cfg_r.max_opacity    <= cfg_pwdata[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FADE_IN:  cfg_prdata = 32'(cfg_r.fade_in_ticks);
      REG_HOLD:     cfg_prdata = 32'(cfg_r.hold_ticks);
      REG_FADE_OUT: cfg_prdata = 32'(cfg_r.fade_out_ticks);
      REG_MAX_OPA:  cfg_prdata = 32'(cfg_r.max_opacity);
      default:      cfg_prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/feg_ctrl.sv =====
// Sequencing state machine of the fade envelope generator.
`timescale 1ns / 1ps
`default_nettype none

module feg_ctrl import feg_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = ST_PHASE;
      end
      ST_PHASE: begin
        cmd.phase = 1'b1;
        state_nxt = sts.need_div ? ST_MUL : ST_FIN;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + DCNT_W'(1);
        if (cnt_r == DCNT_W'(DIV_STEPS - 1)) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // wait for the output register to be free
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MUL |-> ##DIV_STEPS state_r == ST_DIV ##1 state_r == ST_FIN)
    else $error("divider did not run its full step count");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !in_tready ##1 !in_tready)
    else $error("new beat accepted while an item is in flight");

  a_phase_after_calc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.calc |=> cmd.phase)
    else $error("phase select skipped");

endmodule

`default_nettype wire

// ===== src/feg_datapath.sv =====
// Accumulator, phase select, multiplier and serial divider of the envelope.
`timescale 1ns / 1ps
`default_nettype none

module feg_datapath import feg_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cfg_t               cfg,
  input  wire logic [TICK_W-1:0]  in_step,
  input  wire logic               in_paused,
  input  wire cmd_t               cmd,
  output sts_t                    sts,
  input  wire logic               out_tready,
  output logic                    out_tvalid,
  output logic [TICK_W-1:0]       out_leftover,
  output logic [ALPHA_W-1:0]      out_alpha,
  output logic                    out_finished
);

  logic [TICK_W-1:0]  step_r;
  logic               paused_r;
  logic [ACC_W-1:0]   elapsed_r;
  logic [ALPHA_W-1:0] alpha_r;
  logic [TICK_W-1:0]  leftover_r;
  logic               upd_r;
  logic [ACC_W-1:0]   total_r;
  logic [TICK_W:0]    hold_end_r;
  logic [TICK_W-1:0]  a_r;
  logic [TICK_W-1:0]  div_r;
  logic [TICK_W-1:0]  rem_r;
  logic [ALPHA_W-1:0] q_r;
  logic               div_pend_r;
  logic               out_valid_r;
  logic [TICK_W-1:0]  out_leftover_r;
  logic [ALPHA_W-1:0] out_alpha_r;
  logic               out_finished_r;

  // accumulate step
  logic [ACC_W:0]     sum;
  logic [ACC_W:0]     over;
  logic               reach;
  logic               was_short;
  logic [TICK_W-1:0]  leftover_nxt;
  logic [ACC_W-1:0]   elapsed_sat;

  assign sum       = {1'b0, elapsed_r} + (ACC_W+1)'(step_r);
  assign over      = sum - {1'b0, total_r};
  assign reach     = sum >= {1'b0, total_r};
  assign was_short = elapsed_r < total_r;
  assign elapsed_sat = sum[ACC_W] ? '1 : sum[ACC_W-1:0];

  always_comb begin
    if (!reach)         leftover_nxt = '0;
    else if (was_short) leftover_nxt = over[TICK_W-1:0];
    else                leftover_nxt = step_r;
  end

  // phase select
  logic              in_rise;
  logic              in_hold;
  logic [ACC_W-1:0]  t_fall;
  logic              in_fall;
  logic              fade_in_zero;

  assign in_rise      = elapsed_r <= ACC_W'(cfg.fade_in_ticks);
  assign in_hold      = elapsed_r <= ACC_W'(hold_end_r);
  assign t_fall       = elapsed_r - ACC_W'(hold_end_r);
  assign in_fall      = t_fall < ACC_W'(cfg.fade_out_ticks);
  assign fade_in_zero = cfg.fade_in_ticks == '0;

  assign sts.need_div = upd_r &&
                        ((in_rise && !fade_in_zero) || (!in_rise && !in_hold && in_fall));
  assign sts.out_free = !out_valid_r || out_tready;

  // multiplier and restoring divider step
  logic [PROD_W-1:0] prod;
  logic [TICK_W:0]   trial;
  logic [TICK_W:0]   trial_diff;
  logic              trial_ge;

  assign prod       = PROD_W'(a_r) * PROD_W'(cfg.max_opacity);
  assign trial      = {rem_r, q_r[ALPHA_W-1]};
  assign trial_diff = trial - {1'b0, div_r};
  assign trial_ge   = trial >= {1'b0, div_r};

  // durations must only change while idle; the block itself does not enforce it
  always_ff @(posedge clk) begin
    total_r    <= ACC_W'(cfg.fade_in_ticks) + ACC_W'(cfg.hold_ticks)
                + ACC_W'(cfg.fade_out_ticks);
    hold_end_r <= (TICK_W+1)'(cfg.fade_in_ticks) + (TICK_W+1)'(cfg.hold_ticks);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      step_r   <= in_step;
      paused_r <= in_paused;
    end
    if (cmd.calc) begin
      leftover_r <= paused_r ? '0 : leftover_nxt;
      upd_r      <= !paused_r && (leftover_nxt != step_r);
    end
    if (cmd.phase) begin
      if (in_rise) begin
        a_r   <= elapsed_r[TICK_W-1:0];
        div_r <= cfg.fade_in_ticks;
      end else begin
        a_r   <= cfg.fade_out_ticks - t_fall[TICK_W-1:0];
        div_r <= cfg.fade_out_ticks;
      end
    end
    if (cmd.mul) begin
      rem_r <= prod[PROD_W-1:ALPHA_W];
      q_r   <= prod[ALPHA_W-1:0];
    end else if (cmd.div_step) begin
      rem_r <= trial_ge ? trial_diff[TICK_W-1:0] : trial[TICK_W-1:0];
      q_r   <= {q_r[ALPHA_W-2:0], trial_ge};
    end
    if (cmd.finish) begin
      out_leftover_r <= leftover_r;
      out_alpha_r    <= div_pend_r ? q_r : alpha_r;
      out_finished_r <= elapsed_r >= total_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r   <= '0;
      alpha_r     <= MAX_OPA_RST;
      div_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.calc && !paused_r) elapsed_r <= elapsed_sat;
      if (cmd.load) div_pend_r <= 1'b0;
      if (cmd.phase) begin
        div_pend_r <= sts.need_div;
        if (upd_r) begin
          if (in_rise && fade_in_zero)        alpha_r <= cfg.max_opacity;
          else if (!in_rise && in_hold)       alpha_r <= cfg.max_opacity;
          else if (!in_rise && !in_fall)      alpha_r <= '0;
        end
      end
      if (cmd.finish && div_pend_r) alpha_r <= q_r;
      if (cmd.finish)       out_valid_r <= 1'b1;
      else if (out_tready)  out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_leftover = out_leftover_r;
  assign out_alpha    = out_alpha_r;
  assign out_finished = out_finished_r;

  a_paused_no_left: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.calc && paused_r |=> leftover_r == '0 && !upd_r)
    else $error("paused item produced leftover or alpha update");

  a_elapsed_mono: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.calc |=> elapsed_r >= $past(elapsed_r))
    else $error("elapsed time went backwards");

  a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish && div_pend_r |-> q_r <= cfg.max_opacity)
    else $error("ramp quotient above peak opacity");

  a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.calc |=> leftover_r <= step_r)
    else $error("leftover exceeds step");

endmodule

`default_nettype wire

// ===== src/fade_envelope_generator.sv =====
// Top level of the fade envelope generator: registers, controller, datapath.
`timescale 1ns / 1ps
`default_nettype none

// Trapezoidal opacity envelope (fade in, hold, fade out). Each input beat
// carries a tick step in tdata and a pause flag in tuser, and yields exactly
// one output beat with the leftover ticks past the envelope end, the current
// alpha and a finished flag. Items are handled one at a time: a beat that
// lands on a ramp has its result formed by the 8-step restoring divider
// behind the single 16x8 multiplier, and the next beat can be taken in the
// cycle after its result is loaded into the output register; a paused
// beat, a zero step, a beat in the hold, after the end, wholly past the end
// or at zero elapsed time with no fade-in skips the multiply and divide
// steps. A result waiting on the output holds the controller in its last
// state until the output register frees up.
// The output sits in its own register, so the next beat is accepted while a
// result still waits. Register writes (fade_in 0x0, hold 0x4, fade_out 0x8,
// max_opacity 0xC) take effect at the next beat and do not recompute alpha.

module fade_envelope_generator import feg_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] step_ticks
  input  wire logic        in_tuser,   // [0] paused
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [15:0] leftover_ticks, [23:16] alpha, [24] finished
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;
  logic [TICK_W-1:0]  leftover;
  logic [ALPHA_W-1:0] alpha;
  logic               finished;

  feg_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  feg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  feg_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_step      (in_tdata[TICK_W-1:0]),
    .in_paused    (in_tuser),
    .cmd          (cmd),
    .sts          (sts),
    .out_tready   (out_tready),
    .out_tvalid   (out_tvalid),
    .out_leftover (leftover),
    .out_alpha    (alpha),
    .out_finished (finished)
  );

  assign out_tdata = {7'b0, finished, alpha, leftover};

endmodule

`default_nettype wire

// ===== sim/tb_fade_envelope_generator.sv =====
// Self-checking testbench for the fade envelope generator.
`timescale 1ns / 1ps

module tb_fade_envelope_generator;
  import feg_pkg::*;

  localparam int unsigned TICK_MAX      = (1 << TICK_W) - 1;
  localparam int unsigned SPAN_MAX      = 3 * TICK_MAX;
  localparam int unsigned ACC_SAT       = (1 << ACC_W) - 1;
  localparam int unsigned RANDOM_ITEMS  = 1850;
  localparam int unsigned DRAIN_CYCLES  = 20;
  localparam int unsigned HOLD_OFF_LEN  = 300;
  localparam int unsigned LIMIT_CYCLES  = 1_000_000;

  typedef struct packed {
    logic [TICK_W-1:0]  leftover;
    logic [ALPHA_W-1:0] alpha;
    logic               finished;
  } fade_result_t;

  // Scoreboard: tracks envelope state and holds the results each beat should yield.
  class envelope_tracker;
    logic [TICK_W-1:0]  ramp_in;
    logic [TICK_W-1:0]  hold_len;
    logic [TICK_W-1:0]  ramp_out;
    logic [ALPHA_W-1:0] peak;
    int unsigned        elapsed;
    logic [ALPHA_W-1:0] alpha_now;
    fade_result_t       fade_due[$];
    int unsigned        mismatches;
    int unsigned        beats_checked;
    int unsigned        finished_beats;

    function new();
      ramp_in        = FADE_IN_RST;
      hold_len       = HOLD_RST;
      ramp_out       = FADE_OUT_RST;
      peak           = MAX_OPA_RST;
      elapsed        = 0;
      alpha_now      = '1;
      mismatches     = 0;
      beats_checked  = 0;
      finished_beats = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_FADE_IN:  ramp_in  = value[TICK_W-1:0];
        REG_HOLD:     hold_len = value[TICK_W-1:0];
        REG_FADE_OUT: ramp_out = value[TICK_W-1:0];
        REG_MAX_OPA:  peak     = value[ALPHA_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned span();
      return 32'(ramp_in) + 32'(hold_len) + 32'(ramp_out);
    endfunction

    function logic [ALPHA_W-1:0] opacity_at(int unsigned e);
      int unsigned hold_end;
      int unsigned t;
      hold_end = 32'(ramp_in) + 32'(hold_len);
      if (e > 32'(ramp_in)) begin
        if (e > hold_end) begin
          t = e - hold_end;
          if (t >= 32'(ramp_out)) return '0;
          return ALPHA_W'(((32'(ramp_out) - t) * 32'(peak)) / 32'(ramp_out));
        end
        return peak;
      end
      if (ramp_in == '0) return peak;
      return ALPHA_W'((e * 32'(peak)) / 32'(ramp_in));
    endfunction

    function void note_step(logic [TICK_W-1:0] step, logic paused);
      int unsigned  total;
      int unsigned  sum;
      int unsigned  left;
      fade_result_t r;
      total = span();
      left  = 0;
      if (!paused) begin
        sum = elapsed + 32'(step);
        if (sum >= total) left = (elapsed < total) ? sum - total : 32'(step);
        elapsed = (sum > ACC_SAT) ? ACC_SAT : sum;
        // a step that lies wholly past the end keeps the old alpha
        if (left != 32'(step)) alpha_now = opacity_at(elapsed);
      end
      r.leftover = left[TICK_W-1:0];
      r.alpha    = alpha_now;
      r.finished = (elapsed >= total);
      fade_due = {fade_due, r};
    endfunction

    function void check_beat(logic [31:0] beat);
      fade_result_t want;
      if (fade_due.size() == 0) begin
        mismatches++;
        $display("%0t: result beat %h with nothing pending", $time, beat);
        return;
      end
      want = fade_due.pop_front();
      beats_checked++;
      if (beat[24]) finished_beats++;
      if (beat[15:0] !== want.leftover) begin
        mismatches++;
        $display("%0t: leftover_ticks expected %h actual %h", $time, want.leftover, beat[15:0]);
      end
      if (beat[23:16] !== want.alpha) begin
        mismatches++;
        $display("%0t: alpha expected %h actual %h", $time, want.alpha, beat[23:16]);
      end
      if (beat[24] !== want.finished) begin
        mismatches++;
        $display("%0t: finished expected %b actual %b", $time, want.finished, beat[24]);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [15:0] step_ticks
  logic        in_tuser;   // [0] paused
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [15:0] leftover_ticks, [23:16] alpha, [24] finished
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  envelope_tracker tracker = new();
  int unsigned     cycle_count = 0;
  int unsigned     phase_count = 0;
  int unsigned     random_sent = 0;
  bit              steady = 1'b0;
  bit              hold_off = 1'b0;

  fade_envelope_generator dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("%0t: run still busy after %0d cycles", $time, LIMIT_CYCLES);
      $display("tb_fade_envelope_generator: errors");
      $finish;
    end
  end

  // both handshakes are sampled here, before this edge's updates land
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) tracker.note_step(in_tdata, in_tuser);
      if (out_tvalid && out_tready) tracker.check_beat(out_tdata);
    end
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver: random stalls, steady stretches and one long hold-off on request
  initial begin
    int unsigned n;
    out_tready <= 1'b0;
    forever begin
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_LEN) @(posedge clk);
        hold_off = 1'b0;
      end else if (steady) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else begin
        n = gap_len();
        if (n > 0) begin
          out_tready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  task automatic send_step(input logic [15:0] step, input logic paused);
    int unsigned gap;
    gap = steady ? 0 : gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 16'($urandom);
      in_tuser  <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= step;
    in_tuser  <= paused;
    do @(posedge clk); while (!in_tready);
  endtask

  // drop valid, then let every pending result come out before touching registers
  task automatic settle();
    in_tvalid <= 1'b0;
    // let the last accepted beat reach the scoreboard first
    @(posedge clk);
    while (tracker.fade_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    logic [31:0] word;
    word = {16'($urandom), value};  // upper bits are junk the block must drop
    if (idx == REG_MAX_OPA) word[15:8] = 8'($urandom);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= word;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    tracker.set_reg(idx, word);
    @(posedge clk);
  endtask

  task automatic load_envelope(input int unsigned fi, input int unsigned ho,
                               input int unsigned fo, input int unsigned pk);
    write_reg(REG_FADE_IN, 16'(fi));
    write_reg(REG_HOLD, 16'(ho));
    write_reg(REG_FADE_OUT, 16'(fo));
    write_reg(REG_MAX_OPA, 16'(pk));
  endtask

  // Place the envelope end a little past the current elapsed time so the
  // coming steps cross the ramps, the hold and the end.
  task automatic random_phase();
    int unsigned base;
    int unsigned budget;
    int unsigned target;
    int unsigned fi;
    int unsigned ho;
    int unsigned fo;
    int unsigned pk;
    int unsigned count;
    int unsigned step_hi;
    int unsigned r;
    base   = tracker.elapsed;
    budget = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 60) : $urandom_range(100, 1500);
    target = base + budget;
    if (target > SPAN_MAX) target = SPAN_MAX;
    fo = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, budget);
    if (fo > target) fo = target;
    ho = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, budget / 2);
    if (ho > target - fo) ho = target - fo;
    fi = target - fo - ho;
    if (fi > TICK_MAX) begin
      ho = ho + fi - TICK_MAX;
      fi = TICK_MAX;
    end
    if (ho > TICK_MAX) begin
      fo = fo + ho - TICK_MAX;
      ho = TICK_MAX;
    end
    r  = $urandom_range(0, 99);
    pk = (r < 10) ? 0 : (r < 25) ? 255 : $urandom_range(1, 254);
    load_envelope(fi, ho, fo, pk);

    steady = (phase_count % 7 == 3);
    if (phase_count == 2 || phase_count == 17) hold_off = 1'b1;
    count   = $urandom_range(30, 90);
    step_hi = (3 * budget) / count;
    if (step_hi < 1) step_hi = 1;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 12) send_step(16'($urandom), 1'b1);
      else if (r < 17) send_step('0, 1'b0);
      else send_step(16'($urandom_range(1, step_hi)), 1'b0);
    end
    random_sent += count;
    phase_count++;
    settle();
    steady = 1'b0;
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset envelope: paused beats, a zero step, then reaching the one-tick end
    send_step(16'hFFFF, 1'b1);
    send_step(16'h0000, 1'b0);
    send_step(16'hA5A5, 1'b1);
    send_step(16'h0001, 1'b0);
    settle();

    // zero fade-in: hold, both sides of the fade-out, crossing the end, past it
    load_envelope(0, 3, 4, 200);
    send_step(16'd1, 1'b0);
    send_step(16'd2, 1'b0);
    send_step(16'd2, 1'b0);
    send_step(16'd0, 1'b0);
    send_step(16'd3, 1'b0);
    send_step(16'd4, 1'b0);
    send_step(16'h5A5A, 1'b1);
    settle();

    // widest durations, then zero peak opacity
    load_envelope(TICK_MAX, TICK_MAX, TICK_MAX, 255);
    send_step(16'd1, 1'b0);
    send_step(16'd30000, 1'b0);
    send_step(16'd1000, 1'b0);
    settle();
    write_reg(REG_MAX_OPA, 16'd0);
    send_step(16'd7, 1'b0);
    settle();

    while (random_sent < RANDOM_ITEMS) random_phase();

    // full-size steps run the accumulator into saturation
    load_envelope(TICK_MAX, TICK_MAX, TICK_MAX, 128);
    repeat (4) begin
      send_step(16'hFFFF, 1'b0);
      send_step(16'h0000, 1'b1);
    end
    send_step(16'd1, 1'b0);
    send_step(16'd0, 1'b0);
    settle();

    $display("run covered %0d result beats over %0d random envelope settings",
             tracker.beats_checked, phase_count);
    $display("%0d beats reported a finished envelope, final elapsed %0d ticks",
             tracker.finished_beats, tracker.elapsed);
    if (tracker.mismatches == 0 && tracker.fade_due.size() == 0) begin
      $display("tb_fade_envelope_generator: clean");
    end else begin
      $display("tb_fade_envelope_generator: errors");
    end
    $finish;
  end

endmodule
